// ===== hdl/tlm_pkg.sv =====
package tlm_pkg;

  localparam int GRID_SIZE = 5;
  localparam int NPIX      = GRID_SIZE * GRID_SIZE;
  localparam int COL_W     = $clog2(GRID_SIZE);
  localparam int PIX_W     = $clog2(NPIX);

  // bubble centre in Q.16 grid units, 0 .. (GRID_SIZE-1) * 2^16
  localparam int CENT_BASE = (GRID_SIZE - 1) * 32768;
  localparam int CENT_HI   = (GRID_SIZE - 1) * 65536;
  localparam int CENT_W    = $clog2(CENT_HI + 1);
  localparam int DX_W      = CENT_W + 1;
  localparam int SQ_W      = 2 * DX_W - 1;
  localparam int D2_W      = 2 * DX_W;
  localparam int FP_W      = 16 + D2_W;
  localparam int TERM_W    = 49;

  localparam int IDX_W      = 5;
  localparam int LVL_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE        = 2'd3;

  localparam logic [15:0] ALPHA_RST       = 16'd3277;
  localparam logic [7:0]  SENSITIVITY_RST = 8'd20;
  localparam logic [7:0]  BRIGHTNESS_RST  = 8'd255;
  localparam logic [15:0] FADE_RST        = 16'd43909;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SMUL   = 7'b0000010,
    ST_SADD   = 7'b0000100,
    ST_CDIFF  = 7'b0001000,
    ST_CMUL   = 7'b0010000,
    ST_CCLAMP = 7'b0100000,
    ST_PIX    = 7'b1000000
  } tlm_state_t;

  typedef struct packed {
    logic load;
    logic smul;
    logic sadd;
    logic cdiff;
    logic cmul;
    logic cclamp;
    logic issue;
  } tlm_cmd_t;

  typedef struct packed {
    logic pipe_en;
    logic last_pix;
  } tlm_stat_t;

endpackage

// ===== hdl/tlm_ctrl.sv =====
module tlm_ctrl import tlm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tlm_stat_t stat,
  output tlm_cmd_t  cmd
);

  tlm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SMUL;
        end
      end
      ST_SMUL: begin
        cmd.smul  = 1'b1;
        state_nxt = ST_SADD;
      end
      ST_SADD: begin
        cmd.sadd  = 1'b1;
        state_nxt = ST_CDIFF;
      end
      ST_CDIFF: begin
        cmd.cdiff = 1'b1;
        state_nxt = ST_CMUL;
      end
      ST_CMUL: begin
        cmd.cmul  = 1'b1;
        state_nxt = ST_CCLAMP;
      end
      ST_CCLAMP: begin
        cmd.cclamp = 1'b1;
        state_nxt  = ST_PIX;
      end
      ST_PIX: begin
        cmd.issue = stat.pipe_en;
        if (stat.pipe_en && stat.last_pix) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/tlm_dp.sv =====
module tlm_dp import tlm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tlm_cmd_t               cmd,
  output tlm_stat_t              stat,
  input  logic signed [15:0]     in_accel_x,
  input  logic signed [15:0]     in_accel_y,
  input  logic                   in_button_pressed,
  input  logic [15:0]            alpha,
  input  logic [7:0]             sensitivity,
  input  logic [7:0]             brightness,
  input  logic [15:0]            fade,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [IDX_W-1:0]       out_pixel_index,
  output logic [LVL_W-1:0]       out_level,
  output logic                   out_last
);

  // clamp a Q.16 centre to 0 .. CENT_HI
  function automatic logic [CENT_W-1:0] clamp_c(input logic signed [30:0] c);
    logic [CENT_W-1:0] r;
    if (c < 0) begin
      r = '0;
    end else if (c > $signed(31'(CENT_HI))) begin
      r = CENT_W'(CENT_HI);
    end else begin
      r = c[CENT_W-1:0];
    end
    return r;
  endfunction

  // smoothing and centre lanes
  logic signed [32:0] diff_x_r, diff_y_r;
  logic signed [49:0] sprod_x_r, sprod_y_r;
  logic [31:0]        smooth_x_r, smooth_y_r, smooth_x_nxt, smooth_y_nxt;
  logic [31:0]        offset_x_r, offset_y_r;
  logic               btn_r;
  logic signed [32:0] d_x_r, d_y_r;
  logic signed [41:0] cprod_x_r, cprod_y_r;
  logic signed [30:0] csum_x, csum_y;
  logic [CENT_W-1:0]  cx_r, cy_r;

  assign smooth_x_nxt = smooth_x_r + sprod_x_r[47:16];
  assign smooth_y_nxt = smooth_y_r + sprod_y_r[47:16];
  // floor of the scaled tilt difference, sign carried into the sum
  assign csum_x = $signed(31'(CENT_BASE)) + 31'($signed(cprod_x_r[41:12]));
  assign csum_y = $signed(31'(CENT_BASE)) + 31'($signed(cprod_y_r[41:12]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_x_r <= '0;
      smooth_y_r <= '0;
      offset_x_r <= '0;
      offset_y_r <= '0;
    end else if (cmd.sadd) begin
      smooth_x_r <= smooth_x_nxt;
      smooth_y_r <= smooth_y_nxt;
      if (btn_r) begin
        offset_x_r <= smooth_x_nxt;
        offset_y_r <= smooth_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      diff_x_r <= $signed({in_accel_x[15], in_accel_x, 16'd0})
                - $signed({smooth_x_r[31], smooth_x_r});
      diff_y_r <= $signed({in_accel_y[15], in_accel_y, 16'd0})
                - $signed({smooth_y_r[31], smooth_y_r});
      btn_r    <= in_button_pressed;
    end
    if (cmd.smul) begin
      sprod_x_r <= diff_x_r * $signed({1'b0, alpha});
      sprod_y_r <= diff_y_r * $signed({1'b0, alpha});
    end
    if (cmd.cdiff) begin
      d_x_r <= $signed({offset_x_r[31], offset_x_r}) - $signed({smooth_x_r[31], smooth_x_r});
      d_y_r <= $signed({offset_y_r[31], offset_y_r}) - $signed({smooth_y_r[31], smooth_y_r});
    end
    if (cmd.cmul) begin
      cprod_x_r <= d_x_r * $signed({1'b0, sensitivity});
      cprod_y_r <= d_y_r * $signed({1'b0, sensitivity});
    end
    if (cmd.cclamp) begin
      cx_r <= clamp_c(csum_x);
      cy_r <= clamp_c(csum_y);
    end
  end

  // pixel pipeline: squares, fade product, term, level
  logic                   pipe_en;
  logic [COL_W-1:0]       col_r, row_r;
  logic [PIX_W-1:0]       pix_r;
  logic                   pix_last;
  logic [DX_W-1:0]        colpos, rowpos;
  logic signed [DX_W-1:0] dx, dy;
  logic signed [2*DX_W-1:0] sqx, sqy;
  logic [SQ_W-1:0]        sqx_r, sqy_r;
  logic [D2_W-1:0]        d2;
  logic [FP_W-1:0]        fprod_r;
  logic [TERM_W-1:0]      term_r;
  logic [TERM_W+7:0]      lvl_prod;
  logic                   va_r, vb_r, vc_r, out_valid_r;
  logic [IDX_W-1:0]       idx_a_r, idx_b_r, idx_c_r, out_idx_r;
  logic                   last_a_r, last_b_r, last_c_r, out_last_r;
  logic [LVL_W-1:0]       out_level_r;

  assign pipe_en  = !out_valid_r || !out_stall;
  assign pix_last = (pix_r == PIX_W'(NPIX - 1));
  assign stat.pipe_en  = pipe_en;
  assign stat.last_pix = pix_last;

  assign colpos = DX_W'({col_r, 16'd0});
  assign rowpos = DX_W'({row_r, 16'd0});
  assign dx  = $signed({1'b0, cx_r}) - $signed(colpos);
  assign dy  = $signed({1'b0, cy_r}) - $signed(rowpos);
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign d2  = D2_W'(sqx_r) + D2_W'(sqy_r);
  assign lvl_prod = brightness * term_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      pix_r <= '0;
    end else if (cmd.issue) begin
      if (pix_last) begin
        col_r <= '0;
        row_r <= '0;
        pix_r <= '0;
      end else begin
        pix_r <= pix_r + 1'b1;
        if (col_r == COL_W'(GRID_SIZE - 1)) begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      va_r        <= cmd.issue;
      vb_r        <= va_r;
      vc_r        <= vb_r;
      out_valid_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sqx_r    <= sqx[SQ_W-1:0];
      sqy_r    <= sqy[SQ_W-1:0];
      idx_a_r  <= IDX_W'(pix_r);
      last_a_r <= pix_last;

      fprod_r  <= fade * d2;
      idx_b_r  <= idx_a_r;
      last_b_r <= last_a_r;

      if (fprod_r[FP_W-1:48] == '0) begin
        term_r <= (TERM_W'(1) << 48) - TERM_W'(fprod_r[47:0]);
      end else begin
        term_r <= '0;
      end
      idx_c_r  <= idx_b_r;
      last_c_r <= last_b_r;

      out_level_r <= lvl_prod[55:48];
      out_idx_r   <= idx_c_r;
      out_last_r  <= last_c_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_idx_r;
  assign out_level       = out_level_r;
  assign out_last        = out_last_r;

endmodule

// ===== hdl/tilt_level_led_map.sv =====
// Tilt level display: one accelerometer request in, GRID_SIZE^2 pixel requests out.
// A new input is accepted only after the pixel sequencer has issued every pixel of
//   the previous one, one pixel per cycle into a 4-stage pipeline while the result
//   side is not holding it with out_stall.
// Reset (rst_n low, synchronous): smoothed and reference values cleared,
//   registers back to their defaults, pipeline emptied.
module tilt_level_led_map import tlm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [15:0]    in_accel_x,
  input  logic signed [15:0]    in_accel_y,
  input  logic                  in_button_pressed,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [IDX_W-1:0]      out_pixel_index,
  output logic [LVL_W-1:0]      out_level,
  output logic                  out_last,
  // register writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Register file. The host must write it only while no request is in flight; the block does not enforce this.
  logic [15:0] alpha_r;
  logic [7:0]  sensitivity_r;
  logic [7:0]  brightness_r;
  logic [15:0] fade_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r       <= ALPHA_RST;
      sensitivity_r <= SENSITIVITY_RST;
      brightness_r  <= BRIGHTNESS_RST;
      fade_r        <= FADE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ALPHA:       alpha_r       <= cfg_data;
        REG_SENSITIVITY: sensitivity_r <= cfg_data[7:0];
        REG_BRIGHTNESS:  brightness_r  <= cfg_data[7:0];
        REG_FADE:        fade_r        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tlm_cmd_t  cmd;
  tlm_stat_t stat;

  // Sequencer: load, smoothing multiply/add, centre diff/multiply/clamp,
  // then one pixel per cycle while the result side is moving.
  tlm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: two axis lanes for the EMA and bubble centre, plus the pixel
  // pipeline (squared distance, fade product, clipped term, level). The output
  // register is the last pipeline stage; the whole pipe holds on out_stall.
  tlm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_accel_x        (in_accel_x),
    .in_accel_y        (in_accel_y),
    .in_button_pressed (in_button_pressed),
    .alpha             (alpha_r),
    .sensitivity       (sensitivity_r),
    .brightness        (brightness_r),
    .fade              (fade_r),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_pixel_index   (out_pixel_index),
    .out_level         (out_level),
    .out_last          (out_last)
  );

endmodule

// ===== test/tb_tilt_level_led_map.sv =====
`timescale 1ns / 1ps

module tb_tilt_level_led_map;
  import tlm_pkg::*;

  // settle time after the last pixel before a register write or the end
  localparam int SETTLE_CYCLES = 16;
  // generous cap: ~225 frames, each stalled and gapped, plus long holds
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [LVL_W-1:0] lvl;
    logic             last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [15:0]    in_accel_x = '0;
  logic signed [15:0]    in_accel_y = '0;
  logic                  in_button_pressed = 1'b0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [IDX_W-1:0]      out_pixel_index;
  logic [LVL_W-1:0]      out_level;
  logic                  out_last;

  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state: smoothed tilt and captured level reference, signed Q15.16
  logic signed [31:0] ema_x, ema_y, ref_x, ref_y;
  // register shadows
  logic [15:0] alpha_r;
  logic [7:0]  sens_r;
  logic [7:0]  bright_r;
  logic [15:0] fade_r;

  pixel_t pixel_q[$];   // pixels still owed by the block, oldest first
  pixel_t want;
  int     fail_count = 0;
  int     cycle_count = 0;

  // receiver pattern knobs, owned by the test sequence
  int unsigned stall_pct = 0;
  int unsigned hold_len = 0;
  int unsigned hold_seq = 0;
  // receiver internals
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned run_left = 0;

  // sender pacing
  int unsigned burst_left = 0;
  int unsigned max_gap = 0;
  // slowly drifting tilt for the "hand-held" samples
  int tilt_x = 0;
  int tilt_y = 0;

  tilt_level_led_map i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_accel_x        (in_accel_x),
    .in_accel_y        (in_accel_y),
    .in_button_pressed (in_button_pressed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_index   (out_pixel_index),
    .out_level         (out_level),
    .out_last          (out_last),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // one EMA step: s += floor(alpha * (acc - s)), acc lifted to signed Q15.16
  function automatic logic signed [31:0] ema_update(logic signed [31:0] s,
                                                    logic signed [15:0] acc);
    longint sv;
    longint nv;
    sv = longint'(s);
    nv = sv + (((longint'(acc) * 65536 - sv) * longint'(alpha_r)) >>> 16);
    return nv[31:0];
  endfunction

  // bubble centre on one axis in Q.16 grid units, clamped to the grid
  function automatic longint bubble_pos(logic signed [31:0] off,
                                        logic signed [31:0] smo);
    longint d;
    longint c;
    d = longint'(off) - longint'(smo);
    c = longint'(CENT_BASE) + ((d * longint'(sens_r)) >>> 12);
    if (c < 0) c = 0;
    if (c > longint'(CENT_HI)) c = longint'(CENT_HI);
    return c;
  endfunction

  // update tilt state for one accepted sample and queue its whole frame
  task automatic predict_frame(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic btn);
    longint cx, cy, dx, dy, d2, bracket, lvl;
    pixel_t p;
    ema_x = ema_update(ema_x, ax);
    ema_y = ema_update(ema_y, ay);
    if (btn) begin
      ref_x = ema_x;
      ref_y = ema_y;
    end
    cx = bubble_pos(ref_x, ema_x);
    cy = bubble_pos(ref_y, ema_y);
    for (int i = 0; i < NPIX; i++) begin
      dx = cx - longint'(i % GRID_SIZE) * 65536;
      dy = cy - longint'(i / GRID_SIZE) * 65536;
      d2 = dx * dx + dy * dy;
      bracket = (longint'(1) << 48) - longint'(fade_r) * d2;
      lvl = 0;
      if (bracket > 0) lvl = (longint'(bright_r) * bracket) >>> 48;
      p.idx  = i[IDX_W-1:0];
      p.lvl  = lvl[LVL_W-1:0];
      p.last = (i == NPIX - 1);
      pixel_q.push_back(p);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Pixel checker: every accepted pixel against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel request: pixel_index %0d level %0d",
               out_pixel_index, out_level);
        fail_count++;
      end else begin
        want = pixel_q.pop_front();
        if (out_pixel_index !== want.idx) begin
          $error("pixel_index: expected %0d, got %0d", want.idx, out_pixel_index);
          fail_count++;
        end
        if (out_level !== want.lvl) begin
          $error("level: expected %0d, got %0d (pixel %0d)", want.lvl, out_level,
                 want.idx);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, got %0b (pixel %0d)", want.last, out_last,
                 want.idx);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall runs of random length, plus on request one long hold
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (run_left != 0) begin
      run_left <= run_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      run_left  <= $urandom_range(0, 3);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------

  // offer one sample; returns on the edge it is taken, valid left high
  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic btn);
    in_valid          <= 1'b1;
    in_accel_x        <= ax;
    in_accel_y        <= ay;
    in_button_pressed <= btn;
    do @(posedge clk); while (in_stall);
    predict_frame(ax, ay, btn);
  endtask

  task automatic idle_for(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // burst/gap pacing between samples
  task automatic pace();
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 8);
      if (max_gap != 0) idle_for($urandom_range(1, max_gap));
    end
  endtask

  // stop sending and wait until every owed pixel has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all four registers back to back, block idle
  task automatic load_regs(logic [15:0] a, logic [7:0] s, logic [7:0] b,
                           logic [15:0] f);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_ALPHA;
    cfg_data  <= a;
    @(posedge clk);
    cfg_index <= REG_SENSITIVITY;
    cfg_data  <= {8'h00, s};
    @(posedge clk);
    cfg_index <= REG_BRIGHTNESS;
    cfg_data  <= {8'h00, b};
    @(posedge clk);
    cfg_index <= REG_FADE;
    cfg_data  <= f;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    alpha_r  = a;
    sens_r   = s;
    bright_r = b;
    fade_r   = f;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset registers; flat board, capture, then a modest tilt
  task automatic test_level_at_rest();
    send_sample(16'sd0, 16'sd0, 1'b0);
    send_sample(16'sd0, 16'sd0, 1'b1);
    send_sample(16'sd4096, -16'sd4096, 1'b0);
  endtask

  // full-scale readings push the bubble off the grid: centre must saturate
  task automatic test_full_scale_tilt();
    send_sample(16'sh7fff, 16'sh8000, 1'b0);
    send_sample(16'sh8000, 16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 16'sh7fff, 1'b1);
    send_sample(16'sh8000, 16'sh8000, 1'b0);
  endtask

  // alpha = 0: smoothed values frozen whatever comes in
  task automatic test_frozen_smoothing();
    load_regs(16'd0, SENSITIVITY_RST, BRIGHTNESS_RST, FADE_RST);
    send_sample(16'sh7fff, 16'sh8000, 1'b1);
    send_sample(16'sh8000, 16'sh7fff, 1'b0);
  endtask

  // alpha and gain at max: near-raw tracking, large bubble moves
  task automatic test_fast_response();
    load_regs(16'hffff, 8'd255, 8'd200, FADE_RST);
    send_sample(16'sd1000, -16'sd1000, 1'b1);
    send_sample(16'sd1100, -16'sd900, 1'b0);
    send_sample(16'sh8000, 16'sh7fff, 1'b0);
  endtask

  // zero gain: bubble parked at the grid centre
  task automatic test_centered_bubble();
    load_regs(16'h8000, 8'd0, 8'd255, 16'd20000);
    send_sample(16'sd20000, -16'sd20000, 1'b0);
    send_sample(-16'sd5, 16'sd7, 1'b1);
  endtask

  // no falloff (flat field), zero brightness, steepest falloff
  task automatic test_fade_extremes();
    load_regs(ALPHA_RST, SENSITIVITY_RST, 8'd255, 16'd0);
    send_sample(16'sd3000, -16'sd2000, 1'b0);
    load_regs(ALPHA_RST, SENSITIVITY_RST, 8'd0, 16'hffff);
    send_sample(16'sd3000, -16'sd2000, 1'b0);
    load_regs(16'hffff, 8'd30, 8'd255, 16'hffff);
    send_sample(16'sd500, 16'sd500, 1'b1);
    send_sample(16'sd800, 16'sd200, 1'b0);
  endtask

  // receiver holds off for a long time while samples keep coming: the
  // pipeline backs up and in_stall must hold the sender off
  task automatic test_backpressure();
    load_regs(16'd8192, 8'd24, 8'd180, FADE_RST);
    hold_len  <= 400;
    hold_seq  <= hold_seq + 1;
    stall_pct <= 20;
    for (int i = 0; i < 14; i++)
      send_sample(16'($urandom()), 16'($urandom()), (i % 5) == 0);
    drain();
    stall_pct <= 0;
  endtask

  // mostly hand-held samples (small wobble around a drifting tilt, the odd
  // recapture), some full-range noise; random registers per phase
  task automatic test_random_tilt(int n, int unsigned pct, int unsigned gap);
    logic [15:0] a;
    logic [15:0] ax, ay;
    logic        btn;
    if ($urandom_range(3) == 0) a = 16'($urandom_range(1, 65535));
    else a = 16'($urandom_range(256, 16384));
    load_regs(a,
              ($urandom_range(3) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 48)),
              8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    stall_pct  <= pct;
    max_gap     = gap;
    burst_left  = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 75) begin
        tilt_x += int'($urandom_range(0, 400)) - 200;
        tilt_y += int'($urandom_range(0, 400)) - 200;
        if (tilt_x > 8192) tilt_x = 8192;
        if (tilt_x < -8192) tilt_x = -8192;
        if (tilt_y > 8192) tilt_y = 8192;
        if (tilt_y < -8192) tilt_y = -8192;
        ax = 16'(tilt_x + int'($urandom_range(0, 127)) - 64);
        ay = 16'(tilt_y + int'($urandom_range(0, 127)) - 64);
      end else begin
        ax = 16'($urandom());
        ay = 16'($urandom());
      end
      btn = ($urandom_range(99) < 8);
      send_sample(ax, ay, btn);
      // occasionally pause until every owed pixel is out
      if ((i % 16) == 15) drain();
      else pace();
    end
    drain();
  endtask

  initial begin
    ema_x    = '0;
    ema_y    = '0;
    ref_x    = '0;
    ref_y    = '0;
    alpha_r  = ALPHA_RST;
    sens_r   = SENSITIVITY_RST;
    bright_r = BRIGHTNESS_RST;
    fade_r   = FADE_RST;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_level_at_rest();
    test_full_scale_tilt();
    test_frozen_smoothing();
    test_fast_response();
    test_centered_bubble();
    test_fade_extremes();
    test_random_tilt(48, 0, 0);
    test_random_tilt(48, 30, 6);
    test_backpressure();
    test_random_tilt(48, 60, 20);
    test_random_tilt(48, 15, 3);

    drain();
    if (pixel_q.size() != 0) begin
      $error("%0d pixel requests never arrived", pixel_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
